/* hw/rtl/brc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brc_pkg
// Shared constants and controller/datapath interface types for the
// balanced radix converter.
// ----------------------------------------------------------------------------
package brc_pkg;

    localparam int MAX_DIGITS_DEF  = 21;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = 8;

    // base register after reset, and the base used in place of a base of one
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 8'd3;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 8'd3;
    localparam logic [DIGIT_W-1:0] RADIX_ONE   = 8'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new input word
        logic store_zero;  // zero input: one digit of 0
        logic div_start;   // clear remainder before a division
        logic div_step;    // one restoring division step
        logic fix;         // balance the digit, store it, bump the count
        logic pos_init;    // read pointer to the top digit
        logic pos_dec;     // read pointer to the next lower digit
        logic out_load;    // load output registers from the store
    } brc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic q_zero;      // running quotient is zero
        logic count_zero;  // no digit stored yet
        logic count_full;  // digit store is full
    } brc_status_t;

endpackage
`default_nettype wire

/* hw/rtl/brc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brc_datapath
// Base register, bit-serial divider, digit balancing and the digit store.
// ----------------------------------------------------------------------------
module brc_datapath #(
    parameter int MAX_DIGITS  = brc_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = brc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           radix_we,
    input  wire logic [brc_pkg::DIGIT_W-1:0]    radix_wdata,
    input  wire logic [VALUE_WIDTH-1:0]         value,
    input  wire brc_pkg::brc_cmd_t              cmd,
    output brc_pkg::brc_status_t                status,
    output logic signed [brc_pkg::DIGIT_W-1:0]  digit,
    output logic                                last
);

    localparam int DW    = brc_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

    logic [DW-1:0]          radix_reg;
    logic [VALUE_WIDTH-1:0] q_reg;
    logic [VALUE_WIDTH-1:0] q_next;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          rem_next;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [DW-1:0]          rd_data_reg;
    logic signed [DW-1:0]   digit_reg;
    logic                   last_reg;
    logic [DW-1:0]          store [MAX_DIGITS];

    logic [DW-1:0]          base;
    logic [DW-1:0]          half;
    logic [DW:0]            trial;
    logic                   ge;
    logic                   over_half;
    logic [DW-1:0]          bal_digit;

    assign base      = (radix_reg == brc_pkg::RADIX_ONE) ? brc_pkg::RADIX_MIN : radix_reg;
    assign half      = base >> 1;
    assign trial     = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign ge        = trial >= {1'b0, base};
    assign over_half = rem_reg > half;
    assign bal_digit = over_half ? DW'(rem_reg - base) : rem_reg;

    always_comb
    begin
        rem_next = ge ? DW'(trial - {1'b0, base}) : trial[DW-1:0];
        q_next   = {q_reg[VALUE_WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= brc_pkg::RADIX_RESET;
            q_reg     <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (radix_we)
                radix_reg <= radix_wdata | DW'(1);
            if (cmd.load)
                q_reg <= value;
            else if (cmd.div_step)
                q_reg <= q_next;
            else if (cmd.fix && over_half)
                q_reg <= q_reg + VALUE_WIDTH'(1);

            if (cmd.load)
                count_reg <= '0;
            else if (cmd.store_zero || cmd.fix)
                count_reg <= count_reg + CNT_W'(1);

            if (cmd.pos_init)
                pos_reg <= IDX_W'(count_reg - CNT_W'(1));
            else if (cmd.pos_dec)
                pos_reg <= pos_reg - IDX_W'(1);

            if (cmd.out_load)
                last_reg <= (pos_reg == '0);
        end
    end

    // remainder and output digit carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            rem_reg <= '0;
        else if (cmd.div_step)
            rem_reg <= rem_next;
        if (cmd.out_load)
            digit_reg <= rd_data_reg;
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge clk)
    begin
        if (cmd.store_zero)
            store[0] <= '0;
        else if (cmd.fix)
            store[count_reg[IDX_W-1:0]] <= bal_digit;
        rd_data_reg <= store[pos_reg];
    end

    assign status.q_zero     = (q_reg == '0);
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CNT_MAX);
    assign digit             = digit_reg;
    assign last              = last_reg;

endmodule
`default_nettype wire

/* hw/rtl/brc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// brc_ctrl
// Sequencer: division loop per digit, then readout of the stored digits.
// ----------------------------------------------------------------------------
module brc_ctrl #(
    parameter int VALUE_WIDTH = brc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 value_valid,
    output logic                      value_stall,
    output logic                      digit_valid,
    input  wire logic                 digit_stall,
    input  wire logic                 last,
    input  wire brc_pkg::brc_status_t status,
    output brc_pkg::brc_cmd_t         cmd
);

    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(VALUE_WIDTH - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_FIX     = 3'd3;
    localparam logic [2:0] S_SETUP   = 3'd4;
    localparam logic [2:0] S_READ    = 3'd5;
    localparam logic [2:0] S_LOAD    = 3'd6;
    localparam logic [2:0] S_PRESENT = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (value_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.q_zero)
                begin
                    cmd.store_zero = status.count_zero;
                    state_next     = S_SETUP;
                end
                else if (status.count_full)
                    state_next = S_SETUP;
                else
                begin
                    cmd.div_start = 1'b1;
                    bit_next      = BIT_TOP;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = S_FIX;
                else
                    bit_next = bit_reg - BIT_W'(1);
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_CHECK;
            end
            S_SETUP:
            begin
                cmd.pos_init = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
                state_next = S_LOAD;
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_PRESENT;
            end
            S_PRESENT:
            begin
                if (!digit_stall)
                begin
                    if (last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.pos_dec = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    assign value_stall = (state_reg != S_IDLE);
    assign digit_valid = (state_reg == S_PRESENT);

endmodule
`default_nettype wire

/* hw/rtl/balanced_radix_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// balanced_radix_converter
// Converts an unsigned word to signed balanced digits in an odd base.
// ----------------------------------------------------------------------------
// One input word becomes a run of signed balanced digits in the base held in
// the radix register (reset 3, balanced ternary; bit 0 is always forced to
// one, and a base of one acts as 3). Digits leave most significant first,
// leading zeros suppressed, with last set on the least significant digit; a
// zero word gives a single digit 0. One shared restoring divider produces
// one quotient bit per cycle. Each digit takes a division, balancing and a
// loop check; each emitted digit takes a store read, an output load and the
// handshake, which digit_stall can hold. One word is handled at a time;
// value_stall stays high until the last digit of the run has been taken. The
// radix may only be written while idle.
// ----------------------------------------------------------------------------
module balanced_radix_converter #(
    parameter int MAX_DIGITS  = brc_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = brc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // base register write
    input  wire logic                           radix_we,
    input  wire logic [brc_pkg::DIGIT_W-1:0]    radix_wdata,
    // input word
    input  wire logic                           value_valid,
    output logic                                value_stall,
    input  wire logic [VALUE_WIDTH-1:0]         value,
    // output digits
    output logic                                digit_valid,
    input  wire logic                           digit_stall,
    output logic signed [brc_pkg::DIGIT_W-1:0]  digit,
    output logic                                last
);

    brc_pkg::brc_cmd_t    cmd;
    brc_pkg::brc_status_t status;

    // sequencer: division loop, then digit readout with handshake
    brc_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .last        (last),
        .status      (status),
        .cmd         (cmd)
    );

    // base register, serial divider, balancing and digit store
    brc_datapath #(
        .MAX_DIGITS  (MAX_DIGITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .digit       (digit),
        .last        (last)
    );

endmodule
`default_nettype wire

/* sim/tb_balanced_radix_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_balanced_radix_converter
// Self-checking bench for the balanced radix converter. A queue-fed driver
// offers input words, a scoreboard expands each accepted word into its run of
// balanced digits from its own copy of the base register, and a monitor checks
// every digit and last flag in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_balanced_radix_converter;

    localparam int VW = brc_pkg::VALUE_WIDTH_DEF;
    localparam int ND = brc_pkg::MAX_DIGITS_DEF;
    localparam int DW = brc_pkg::DIGIT_W;

    // watchdog limit, set with ample margin over the slowest run
    localparam int unsigned CYCLE_LIMIT      = 2_500_000;
    localparam int unsigned HOLD_CYCLES      = 3000;
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned RANDOM_PER_PHASE = 35;
    localparam int          PHASES           = 12;
    localparam int          PLAN_LEN         = 9;

    // base settings after the reset phase; the rest are random
    localparam logic [DW-1:0] RADIX_PLAN [PLAN_LEN] = '{
        8'd255, 8'd0, 8'd5, 8'd254, 8'd1, 8'd2, 8'd128, 8'd7, 8'd3
    };

    // reset base: tiny words, full carry chains, powers of three, bit patterns
    localparam logic [VW-1:0] TERNARY_WORDS [17] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd13, 32'd14,
        32'd1743392200, 32'd1743392201, 32'd3486784401, 32'd3486784400,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    // base 255: digits at +127 and -127
    localparam logic [VW-1:0] WIDE_BASE_WORDS [5] = '{
        32'd127, 32'd128, 32'd32512, 32'd32513, 32'hFFFF_FFFF
    };

    typedef logic signed [DW-1:0] digit_t;

    typedef struct {
        digit_t digit;
        logic   last;
    } digit_word_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 radix_we    = 1'b0;
    logic [DW-1:0]        radix_wdata = '0;
    logic                 value_valid = 1'b0;
    logic [VW-1:0]        value       = '0;
    logic                 digit_stall = 1'b0;
    wire                  value_stall;
    wire                  digit_valid;
    wire signed [DW-1:0]  digit;
    wire                  last;

    logic [VW-1:0]        word_q [$];
    digit_word_t          digit_exp_q [$];
    logic [DW-1:0]        radix_shadow   = brc_pkg::RADIX_RESET;
    int unsigned          words_pushed   = 0;
    int unsigned          words_taken    = 0;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          send_gap       = 0;
    int unsigned          recv_wait      = 0;
    bit                   send_idle_en   = 1'b1;
    bit                   recv_idle_en   = 1'b1;
    bit                   hold_go        = 1'b0;
    logic                 recv_hold      = 1'b0;

    balanced_radix_converter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // expand one word into its balanced digits, most significant first
    function automatic void expand_digits(input logic [VW-1:0] w);
        longint unsigned base;
        longint unsigned half;
        longint unsigned rem;
        longint unsigned quo;
        digit_t          run [ND];
        int              n;
        digit_word_t     e;
        base = radix_shadow | 8'd1;
        // a base of one means nothing, it acts as base 3
        if (base < brc_pkg::RADIX_MIN)
            base = brc_pkg::RADIX_MIN;
        half = (base - 1) / 2;
        quo  = w;
        n    = 0;
        // zero word still gives one digit
        if (quo == 0)
        begin
            run[0] = '0;
            n      = 1;
        end
        while (quo != 0 && n < ND)
        begin
            rem = quo % base;
            quo = quo / base;
            if (rem > half)
            begin
                // negative digit, carry one upward
                run[n] = digit_t'(longint'(rem) - longint'(base));
                quo++;
            end
            else
                run[n] = digit_t'(rem);
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            e.digit = run[k];
            e.last  = (k == 0);
            digit_exp_q.push_back(e);
        end
    endfunction

    function automatic int unsigned draw_gap(input bit enable);
        return enable ? $urandom_range(0, 10) : 0;
    endfunction

    function automatic logic [VW-1:0] draw_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 300);
            1:       return $urandom >> $urandom_range(0, VW - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10)
            $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic offer(input logic [VW-1:0] w);
        word_q.push_back(w);
        words_pushed++;
    endtask

    // every word taken and every digit back, then let the block settle
    task automatic drain();
        while (words_taken != words_pushed || digit_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [DW-1:0] w);
        @(posedge clk);
        radix_we    <= 1'b1;
        radix_wdata <= w;
        @(posedge clk);
        radix_we    <= 1'b0;
        radix_shadow = w | 8'd1;
    endtask

    // word driver: a word stays put while stalled, then the next one follows
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            value       <= '0;
            send_gap    <= 0;
        end
        else if (!(value_valid && value_stall))
        begin
            if (value_valid)
            begin
                expand_digits(value);
                words_taken++;
            end
            if (send_gap != 0)
            begin
                send_gap    <= send_gap - 1;
                value_valid <= 1'b0;
            end
            else if (word_q.size() != 0)
            begin
                value_valid <= 1'b1;
                value       <= word_q.pop_front();
                send_gap    <= draw_gap(send_idle_en);
            end
            else
                value_valid <= 1'b0;
        end
    end

    // digit monitor: checks each taken digit, then stalls a random while
    always @(posedge clk or negedge rst_n)
    begin : digit_monitor
        int unsigned wait_n;
        digit_word_t e;
        if (!rst_n)
        begin
            digit_stall <= 1'b0;
            recv_wait   <= 0;
        end
        else
        begin
            wait_n = (recv_wait != 0) ? recv_wait - 1 : 0;
            if (digit_valid && !digit_stall)
            begin
                wait_n = draw_gap(recv_idle_en);
                if (digit_exp_q.size() == 0)
                    note_mismatch($sformatf("unexpected digit %0d last %0b", digit, last));
                else
                begin
                    e = digit_exp_q.pop_front();
                    if (e.digit !== digit || e.last !== last)
                        note_mismatch($sformatf("digit exp %0d last %0b, got %0d last %0b",
                                                e.digit, e.last, digit, last));
                end
            end
            recv_wait   <= wait_n;
            digit_stall <= recv_hold || (wait_n != 0);
        end
    end

    // long receiver hold so the block backs up and stalls its input
    initial
    begin : long_hold
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_balanced_radix_converter failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [DW-1:0] w;
        w = brc_pkg::RADIX_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            // phase 0 runs on the reset base; later phases reprogram it idle
            if (p > 0)
            begin
                drain();
                w = (p <= PLAN_LEN) ? RADIX_PLAN[p - 1] : 8'($urandom_range(0, 255));
                write_radix(w);
            end
            if (p == 0)
            begin
                send_idle_en = 1'b1;
                recv_idle_en = 1'b1;
            end
            else if (p == 5)
            begin
                // back-to-back stretch with no idling
                send_idle_en = 1'b0;
                recv_idle_en = 1'b0;
            end
            else
            begin
                send_idle_en = ($urandom_range(0, 3) != 0);
                recv_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (p == 0)
                foreach (TERNARY_WORDS[i])
                    offer(TERNARY_WORDS[i]);
            if (p == 1)
                foreach (WIDE_BASE_WORDS[i])
                    offer(WIDE_BASE_WORDS[i]);
            if (p == 2)
                hold_go = 1'b1;
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                offer(draw_value());
        end
        drain();
        if (mismatch_count == 0)
            $display("tb_balanced_radix_converter passed");
        else
            $display("tb_balanced_radix_converter failed");
        $finish;
    end

endmodule
